FILE: hdl/ssmsd_pkg.sv
// Package: shared types, constants and the character table of the display multiplexer.
`default_nettype none
package ssmsd_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int MAX_TEXT    = 8;
  localparam int HEAD_CHARS  = 4;

  localparam logic [1:0] ACT_REFRESH   = 2'd0;
  localparam logic [1:0] ACT_ROLL      = 2'd1;
  localparam logic [1:0] ACT_LOAD_STAT = 2'd2;
  localparam logic [1:0] ACT_LOAD_ROLL = 2'd3;

  localparam logic [7:0] DOT_BIT    = 8'h80;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [2:0] DOT_NONE   = 3'd5;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] text_head;
    logic [31:0] text_tail;
    logic [3:0]  text_length;
    logic [2:0]  dot_position;
  } in_item_t;

  typedef struct packed {
    logic [1:0] digit_select;
    logic [6:0] segments;
    logic       decimal_point;
  } out_item_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] seg;
  } char_lookup_t;

  function automatic char_lookup_t char_pattern(input logic [7:0] ch);
    char_lookup_t r;
    r.hit = 1'b1;
    case (ch)
      "0":     r.seg = 7'h3F;
      "1":     r.seg = 7'h06;
      "2":     r.seg = 7'h5B;
      "3":     r.seg = 7'h4F;
      "4":     r.seg = 7'h66;
      "5":     r.seg = 7'h6D;
      "6":     r.seg = 7'h7D;
      "7":     r.seg = 7'h07;
      "8":     r.seg = 7'h7F;
      "9":     r.seg = 7'h6F;
      "A":     r.seg = 7'h77;
      "C":     r.seg = 7'h39;
      " ":     r.seg = 7'h00;
      "r":     r.seg = 7'h50;
      "d":     r.seg = 7'h5E;
      "P":     r.seg = 7'h73;
      "n":     r.seg = 7'h54;
      "o":     r.seg = 7'h5C;
      "i":     r.seg = 7'h10;
      "I":     r.seg = 7'h30;
      "-":     r.seg = 7'h40;
      "L":     r.seg = 7'h38;
      "u":     r.seg = 7'h1C;
      default: begin
        r.hit = 1'b0;
        r.seg = 7'h00;
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/ssmsd_in_stage.sv
// Input register stage: holds one accepted item until the core takes it.
`default_nettype none
module ssmsd_in_stage
  import ssmsd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          item_valid,
  input  wire logic     item_take,
  output in_item_t      item_data
);

  logic     valid_r, valid_nxt;
  in_item_t data_r;

  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/ssmsd_core.sv
// Display state, per-item update logic and the result register.
`default_nettype none
module ssmsd_core
  import ssmsd_pkg::*;
#(
  parameter int TAIL_LIMIT = 4,
  parameter int DUTY_TOP   = 10
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     item_valid,
  output logic          item_take,
  input  wire in_item_t item_data,
  input  wire logic [3:0] brightness,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  localparam int TIDX_W = (TAIL_LIMIT > 1) ? $clog2(TAIL_LIMIT) : 1;

  logic [7:0] shown_r [HEAD_CHARS];
  logic [7:0] shown_nxt [HEAD_CHARS];
  logic [7:0] saved_r [HEAD_CHARS];
  logic [7:0] tail_r [TAIL_LIMIT];
  logic [2:0] tail_count_r, tail_count_nxt;
  logic       rolling_r, rolling_nxt;
  logic [2:0] roll_index_r, roll_index_nxt;
  logic [2:0] dot_digit_r, dot_digit_nxt;
  logic [2:0] lit_scan_r, lit_scan_nxt;
  logic [2:0] blank_scan_r, blank_scan_nxt;
  logic [3:0] duty_r, duty_nxt;
  logic [7:0] hold_r, hold_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r, out_nxt;

  logic [3:0]   len_c;
  logic [3:0]   tail_n;
  logic         emit;
  logic [1:0]   emit_digit;
  logic [7:0]   cur_ch;
  char_lookup_t lk;
  logic [3:0]   duty_step;

  assign item_take = item_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    len_c  = (item_data.text_length > 4'(MAX_TEXT)) ? 4'(MAX_TEXT) : item_data.text_length;
    tail_n = (len_c > 4'(HEAD_CHARS)) ? len_c - 4'(HEAD_CHARS) : 4'd0;
    if (tail_n > 4'(TAIL_LIMIT)) begin
      tail_n = 4'(TAIL_LIMIT);
    end
  end

  assign cur_ch    = shown_r[lit_scan_r[1:0]];
  assign lk        = char_pattern(cur_ch);
  assign duty_step = (duty_r != 4'd0) ? duty_r - 4'd1 : 4'(DUTY_TOP);

  always_comb begin
    for (int i = 0; i < HEAD_CHARS; i++) begin
      shown_nxt[i] = shown_r[i];
    end
    tail_count_nxt = tail_count_r;
    rolling_nxt    = rolling_r;
    roll_index_nxt = roll_index_r;
    dot_digit_nxt  = dot_digit_r;
    lit_scan_nxt   = lit_scan_r;
    blank_scan_nxt = blank_scan_r;
    duty_nxt       = duty_r;
    hold_nxt       = hold_r;
    emit           = 1'b0;
    emit_digit     = 2'd0;

    if (item_take) begin
      unique case (item_data.action)
        ACT_REFRESH: begin
          if (duty_r < brightness) begin
            if (lit_scan_r < 3'(DIGIT_COUNT)) begin
              if (cur_ch == CHAR_DOT) begin
                hold_nxt = DOT_BIT;
              end else if (lk.hit) begin
                hold_nxt = {(lit_scan_r == dot_digit_r), lk.seg};
              end
              emit         = 1'b1;
              emit_digit   = lit_scan_r[1:0];
              lit_scan_nxt = lit_scan_r + 3'd1;
            end else begin
              lit_scan_nxt = 3'd0;
              duty_nxt     = duty_step;
            end
          end else if (blank_scan_r < 3'(DIGIT_COUNT)) begin
            hold_nxt       = 8'h00;
            emit           = 1'b1;
            emit_digit     = blank_scan_r[1:0];
            blank_scan_nxt = blank_scan_r + 3'd1;
          end else begin
            blank_scan_nxt = 3'd0;
            duty_nxt       = duty_step;
          end
        end
        ACT_ROLL: begin
          if (rolling_r) begin
            for (int i = 0; i < HEAD_CHARS - 1; i++) begin
              shown_nxt[i] = shown_r[i + 1];
            end
            if (roll_index_r < tail_count_r) begin
              shown_nxt[HEAD_CHARS - 1] = tail_r[roll_index_r[TIDX_W-1:0]];
              roll_index_nxt = roll_index_r + 3'd1;
            end else begin
              roll_index_nxt = 3'd0;
              for (int i = 0; i < HEAD_CHARS; i++) begin
                shown_nxt[i] = saved_r[i];
              end
            end
          end
        end
        ACT_LOAD_STAT: begin
          for (int i = 0; i < HEAD_CHARS; i++) begin
            shown_nxt[i] = item_data.text_head[8*i +: 8];
          end
          dot_digit_nxt = item_data.dot_position;
          rolling_nxt   = 1'b0;
        end
        ACT_LOAD_ROLL: begin
          for (int i = 0; i < HEAD_CHARS; i++) begin
            if (4'(i) < len_c) begin
              shown_nxt[i] = item_data.text_head[8*i +: 8];
            end
          end
          tail_count_nxt = tail_n[2:0];
          rolling_nxt    = 1'b1;
          roll_index_nxt = 3'd0;
        end
        default: begin
        end
      endcase
    end

    // Result register: load a new result, or drop the one just taken.
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_nxt.digit_select  = emit_digit;
      out_nxt.segments      = hold_nxt[6:0];
      out_nxt.decimal_point = hold_nxt[7];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HEAD_CHARS; i++) begin
        shown_r[i] <= CHAR_ZERO;
      end
      tail_count_r <= 3'd0;
      rolling_r    <= 1'b0;
      roll_index_r <= 3'd0;
      dot_digit_r  <= DOT_NONE;
      lit_scan_r   <= 3'd0;
      blank_scan_r <= 3'd0;
      duty_r       <= 4'd10;
      hold_r       <= 8'h00;
      out_valid_r  <= 1'b0;
    end else begin
      for (int i = 0; i < HEAD_CHARS; i++) begin
        shown_r[i] <= shown_nxt[i];
      end
      tail_count_r <= tail_count_nxt;
      rolling_r    <= rolling_nxt;
      roll_index_r <= roll_index_nxt;
      dot_digit_r  <= dot_digit_nxt;
      lit_scan_r   <= lit_scan_nxt;
      blank_scan_r <= blank_scan_nxt;
      duty_r       <= duty_nxt;
      hold_r       <= hold_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers: saved head, tail characters and the result.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (item_take && item_data.action == ACT_LOAD_ROLL) begin
      for (int i = 0; i < HEAD_CHARS; i++) begin
        if (4'(i) < len_c) begin
          saved_r[i] <= item_data.text_head[8*i +: 8];
        end
      end
      for (int i = 0; i < TAIL_LIMIT; i++) begin
        if (4'(i) < tail_n) begin
          tail_r[i] <= item_data.text_tail[8*i +: 8];
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/seven_segment_mux_scroll_dimmer_top.sv
// Top level of the four-digit seven-segment multiplexer with scroll and dimming.
//
// Usage:
//   in_*  : item channel (valid/ready). Each item is a refresh tick, a roll
//           tick, a static message load or a rolling message load.
//   out_* : result channel (valid/ready). A refresh tick that drives a digit
//           yields one item: digit select, segments a..g and dot. Ticks that
//           end a scan pass, roll ticks and loads yield nothing.
//   cfg_* : brightness write, taken on any edge with cfg_we high; write it
//           only while the block is idle. Levels above ten light every step.
// Timing: an accepted item waits in the input register until the core takes it,
//   then the core updates the display state and loads the result register;
//   out_valid rises in the cycle after the core takes its item.
//   One item per cycle is sustained while out_ready stays high; the rate is set
//   by the update between input register and result register.
// Reset: all digits show '0', no dot, brightness ten, duty counter at ten,
//   static mode, both channels empty.
// Stall: while out_ready is low a held result stays put; the core holds the
//   next item in the input register and in_ready drops once that is full.
`default_nettype none
module seven_segment_mux_scroll_dimmer_top
  import ssmsd_pkg::*;
#(
  parameter int TAIL_LIMIT = 4,
  parameter int DUTY_TOP   = 10
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_wdata
);

  logic [3:0] bright_level_r;
  logic       item_valid;
  logic       item_take;
  in_item_t   item_data;

  // Brightness register: lit duty steps out of DUTY_TOP + 1.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_level_r <= 4'd10;
    end else if (cfg_we) begin
      bright_level_r <= cfg_wdata;
    end
  end

  // Hold one item ahead of the core.
  ssmsd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item_data  (item_data)
  );

  // Advance the display state and register the result.
  ssmsd_core #(
    .TAIL_LIMIT (TAIL_LIMIT),
    .DUTY_TOP   (DUTY_TOP)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item_data  (item_data),
    .brightness (bright_level_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

FILE: tb/ssmsd_checker.sv
// Checker: watches both channels, predicts each digit drive and compares it with the block.
module ssmsd_checker
  import ssmsd_pkg::*;
#(
  parameter int TAIL_LIMIT = 4,
  parameter int DUTY_TOP   = 10
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire in_item_t   in_data,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire out_item_t  out_data,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_wdata,
  output int              fail_count,
  output int              pending,
  output int              drives_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] RESET_LEVEL = 4'd10;

  // Display state as the block should hold it
  logic [3:0] level;
  logic [7:0] shown [DIGIT_COUNT];
  logic [7:0] saved [DIGIT_COUNT];
  logic [7:0] tail  [DIGIT_COUNT];
  logic [2:0] tail_cnt;
  logic [2:0] roll_pos;
  logic [2:0] dot_digit;
  logic [2:0] lit_pos;
  logic [2:0] blank_pos;
  logic [3:0] duty;
  logic [7:0] hold;
  logic       rolling;

  out_item_t drive_q[$];
  int        errors;
  int        drives;

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("tb: mismatch on %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
    errors++;
  endtask

  task automatic push_drive(input logic [2:0] pos);
    out_item_t r;
    r.digit_select  = pos[1:0];
    r.segments      = hold[6:0];
    r.decimal_point = hold[7];
    drive_q.push_back(r);
  endtask

  task automatic advance_duty();
    if (duty != 4'd0) duty = duty - 4'd1;
    else duty = 4'(DUTY_TOP);
  endtask

  // Apply one accepted item to the display state; queue the drive it causes
  task automatic scan_display(input in_item_t it);
    logic [7:0] ch;
    logic [6:0] seg;
    logic       known;
    int         len;
    int         n;
    int         i;
    case (it.action)
      ACT_REFRESH: begin
        if (duty < level) begin
          if (lit_pos < DIGIT_COUNT) begin
            ch    = shown[lit_pos[1:0]];
            known = 1'b1;
            seg   = 7'h00;
            case (ch)
              "0": seg = 7'h3F;
              "1": seg = 7'h06;
              "2": seg = 7'h5B;
              "3": seg = 7'h4F;
              "4": seg = 7'h66;
              "5": seg = 7'h6D;
              "6": seg = 7'h7D;
              "7": seg = 7'h07;
              "8": seg = 7'h7F;
              "9": seg = 7'h6F;
              "A": seg = 7'h77;
              "C": seg = 7'h39;
              " ": seg = 7'h00;
              "r": seg = 7'h50;
              "d": seg = 7'h5E;
              "P": seg = 7'h73;
              "n": seg = 7'h54;
              "o": seg = 7'h5C;
              "i": seg = 7'h10;
              "I": seg = 7'h30;
              "-": seg = 7'h40;
              "L": seg = 7'h38;
              "u": seg = 7'h1C;
              default: known = 1'b0;
            endcase
            // an unknown character keeps whatever pattern is held
            if (ch == CHAR_DOT) hold = DOT_BIT;
            else if (known) hold = {(lit_pos == dot_digit), seg};
            push_drive(lit_pos);
            lit_pos = lit_pos + 3'd1;
          end else begin
            lit_pos = 3'd0;
            advance_duty();
          end
        end else if (blank_pos < DIGIT_COUNT) begin
          hold = 8'h00;
          push_drive(blank_pos);
          blank_pos = blank_pos + 3'd1;
        end else begin
          blank_pos = 3'd0;
          advance_duty();
        end
      end
      ACT_ROLL: begin
        if (rolling) begin
          for (i = 0; i < DIGIT_COUNT - 1; i++) shown[i] = shown[i + 1];
          if (roll_pos < tail_cnt) begin
            shown[DIGIT_COUNT - 1] = tail[roll_pos[1:0]];
            roll_pos = roll_pos + 3'd1;
          end else begin
            roll_pos = 3'd0;
            for (i = 0; i < DIGIT_COUNT; i++) shown[i] = saved[i];
          end
        end
      end
      ACT_LOAD_STAT: begin
        for (i = 0; i < HEAD_CHARS; i++) shown[i] = it.text_head[8 * i +: 8];
        dot_digit = it.dot_position;
        rolling   = 1'b0;
      end
      default: begin
        len = int'(it.text_length);
        if (len > MAX_TEXT) len = MAX_TEXT;
        for (i = 0; i < HEAD_CHARS && i < len; i++) begin
          shown[i] = it.text_head[8 * i +: 8];
          saved[i] = it.text_head[8 * i +: 8];
        end
        n = (len > HEAD_CHARS) ? len - HEAD_CHARS : 0;
        if (n > TAIL_LIMIT) n = TAIL_LIMIT;
        for (i = 0; i < n; i++) tail[i] = it.text_tail[8 * i +: 8];
        tail_cnt = 3'(n);
        rolling  = 1'b1;
        roll_pos = 3'd0;
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    int        i;
    if (!rst_n) begin
      level = RESET_LEVEL;
      for (i = 0; i < DIGIT_COUNT; i++) begin
        shown[i] = CHAR_ZERO;
        saved[i] = 8'h00;
        tail[i]  = 8'h00;
      end
      tail_cnt  = 3'd0;
      rolling   = 1'b0;
      roll_pos  = 3'd0;
      dot_digit = DOT_NONE;
      lit_pos   = 3'd0;
      blank_pos = 3'd0;
      duty      = 4'd10;
      hold      = 8'h00;
      drive_q.delete();
    end else begin
      // drain before predicting: a result never belongs to an item taken at the same edge
      if (out_valid && out_ready) begin
        if (drive_q.size() == 0) begin
          report_mismatch("result with no drive waiting", 0, int'(out_data));
        end else begin
          want = drive_q.pop_front();
          drives++;
          if (out_data.digit_select !== want.digit_select)
            report_mismatch("digit_select", want.digit_select, out_data.digit_select);
          if (out_data.segments !== want.segments)
            report_mismatch("segments", want.segments, out_data.segments);
          if (out_data.decimal_point !== want.decimal_point)
            report_mismatch("decimal_point", want.decimal_point, out_data.decimal_point);
        end
      end
      if (in_valid && in_ready) scan_display(in_data);
      if (cfg_we) level = cfg_wdata;
    end
    fail_count  <= errors;
    pending     <= drive_q.size();
    drives_seen <= drives;
  end

endmodule

FILE: tb/tb.sv
// Testbench top: drives the display multiplexer with ticks and loads and gives the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ssmsd_pkg::*;

  localparam int TAIL_LIMIT      = 4;
  localparam int DUTY_TOP        = 10;
  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 9;
  localparam int IDLE_PCT        = 21;
  localparam int PHASES          = 8;
  localparam int PHASE_ITEMS     = 230;
  localparam int QUIET_PHASE     = 2;    // no idling on either side
  localparam int HOLD_PHASE      = 4;    // receiver holds off at the start
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int SETTLE_CYCLES   = 4;    // margin for items still in the pipe
  localparam int DRAIN_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT  = 2000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  int chk_fails;
  int chk_pending;
  int chk_drives;

  // Stimulus bookkeeping
  bit quiet_phase;
  bit hold_req;
  bit primed;        // all four saved head entries written by a rolling load
  int items_sent;
  int idle_run;

  // Characters the display knows, plus the dot; random bytes cover the rest
  string glyph_set = "0123456789AC rdPnoiI-Lu.";

  seven_segment_mux_scroll_dimmer_top #(
    .TAIL_LIMIT (TAIL_LIMIT),
    .DUTY_TOP   (DUTY_TOP)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ssmsd_checker #(
    .TAIL_LIMIT (TAIL_LIMIT),
    .DUTY_TOP   (DUTY_TOP)
  ) chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (chk_fails),
    .pending     (chk_pending),
    .drives_seen (chk_drives)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Receiver: random back-pressure, none in the quiet phase, and one long
  // hold-off on request so the block fills up and drops in_ready.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (quiet_phase) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long
  initial begin
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_run = 0;
      else idle_run++;
    end
    $display("tb: watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
    $display("tb: FAIL");
    $finish;
  end

  function automatic in_item_t mk_item(input logic [1:0] act, input logic [31:0] head,
                                       input logic [31:0] tail, input logic [3:0] len,
                                       input logic [2:0] dot);
    return {act, head, tail, len, dot};
  endfunction

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 99) < 75) return glyph_set[$urandom_range(0, glyph_set.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] pick_text();
    return {pick_char(), pick_char(), pick_char(), pick_char()};
  endfunction

  // Offer one item and hold it until taken. Called right after a rising edge.
  // Drop valid only for a gap or after the last item of a burst, so valid
  // never gets two assignments in one step.
  task automatic send_item(input in_item_t it, input bit last);
    int gap;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (it.action == ACT_LOAD_ROLL && it.text_length >= HEAD_CHARS) primed = 1'b1;
    gap = 0;
    if (!quiet_phase) while ($urandom_range(0, 99) < IDLE_PCT) gap++;
    if (last || gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every predicted drive has come out, then let loads and
  // pass-end ticks still in the pipe run through.
  task automatic settle();
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    in_item_t   it;
    int         p;
    int         n;
    int         r;
    logic [3:0] lvl;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    quiet_phase = 1'b0;
    hold_req    = 1'b0;
    primed      = 1'b0;
    items_sent  = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, at the reset brightness.
    // The duty counter starts at ten, so the first pass is blanked; the
    // pass-end tick steps it down and the next pass is lit.
    send_item(mk_item(ACT_REFRESH, '0, '0, 4'd0, 3'd0), 1'b0);
    send_item(mk_item(ACT_REFRESH, '1, '1, 4'd15, 3'd7), 1'b0);
    repeat (3) send_item(mk_item(ACT_REFRESH, '0, '1, 4'd0, 3'd7), 1'b0);
    // Static message: a digit, the dot character, a dotted letter, an unknown byte
    send_item(mk_item(ACT_LOAD_STAT, {8'hFF, "A", CHAR_DOT, "8"}, '0, 4'd0, 3'd2), 1'b0);
    repeat (5) send_item(mk_item(ACT_REFRESH, '0, '0, 4'd0, 3'd0), 1'b0);
    // Roll tick while static does nothing
    send_item(mk_item(ACT_ROLL, '1, '1, 4'd15, 3'd7), 1'b0);
    // Full eight-character rolling message: four tail feeds, then the head comes back
    send_item(mk_item(ACT_LOAD_ROLL, {"3", "2", "1", "0"}, {"u", "L", "C", "A"}, 4'd8, 3'd0),
              1'b0);
    repeat (5) send_item(mk_item(ACT_ROLL, '0, '0, 4'd0, 3'd0), 1'b0);
    send_item(mk_item(ACT_REFRESH, '0, '0, 4'd0, 3'd0), 1'b0);
    // Length above eight counts as eight
    send_item(mk_item(ACT_LOAD_ROLL, '1, '1, 4'd15, 3'd7), 1'b0);
    send_item(mk_item(ACT_ROLL, '0, '0, 4'd0, 3'd0), 1'b0);
    send_item(mk_item(ACT_REFRESH, '0, '0, 4'd0, 3'd0), 1'b0);
    // Short message: only two head positions written, roll restores at once
    send_item(mk_item(ACT_LOAD_ROLL, {"-", "-", "i", "n"}, '1, 4'd2, 3'd0), 1'b0);
    send_item(mk_item(ACT_ROLL, '0, '0, 4'd0, 3'd0), 1'b0);
    send_item(mk_item(ACT_LOAD_ROLL, '0, '1, 4'd0, 3'd7), 1'b0);
    send_item(mk_item(ACT_ROLL, '0, '0, 4'd0, 3'd0), 1'b0);
    // All-zero static load, then a dot on digit zero
    send_item(mk_item(ACT_LOAD_STAT, '0, '0, 4'd0, 3'd0), 1'b0);
    send_item(mk_item(ACT_REFRESH, '0, '0, 4'd0, 3'd0), 1'b0);
    send_item(mk_item(ACT_LOAD_STAT, {"u", "L", "o", "C"}, '1, 4'd15, 3'd0), 1'b0);
    repeat (3) send_item(mk_item(ACT_REFRESH, '1, '0, 4'd8, 3'd3), 1'b0);

    // Random phases, each at its own brightness. Phase zero runs on from the
    // directed part at the reset level; the rest cover off, full, above ten.
    for (p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        settle();
        case (p)
          1:       lvl = 4'd0;
          2:       lvl = 4'd15;
          3:       lvl = 4'd5;
          4:       lvl = 4'd11;
          5:       lvl = 4'd1;
          6:       lvl = 4'd10;
          default: lvl = 4'($urandom_range(0, 15));
        endcase
        cfg_we    <= 1'b1;
        cfg_wdata <= lvl;
        @(posedge clk);
        cfg_we    <= 1'b0;
      end
      quiet_phase = (p == QUIET_PHASE);
      if (p == HOLD_PHASE) hold_req = 1'b1;

      n = 0;
      while (n < PHASE_ITEMS) begin
        // start with garbage everywhere; ticks ignore the text fields
        it.text_head    = $urandom;
        it.text_tail    = $urandom;
        it.text_length  = 4'($urandom_range(0, 15));
        it.dot_position = 3'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (r < 64) begin
          it.action = ACT_REFRESH;
        end else if (r < 82) begin
          it.action = ACT_ROLL;
        end else if (r < 91) begin
          it.action    = ACT_LOAD_STAT;
          it.text_head = pick_text();
        end else begin
          it.action    = ACT_LOAD_ROLL;
          it.text_head = pick_text();
          it.text_tail = pick_text();
          if ($urandom_range(0, 99) < 70) it.text_length = 4'($urandom_range(4, 8));
          // never let a roll restore a saved head entry nobody wrote
          if (!primed && it.text_length < HEAD_CHARS) it.text_length += 4'd4;
        end
        n++;
        send_item(it, n >= PHASE_ITEMS);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d items over %0d brightness phases, %0d digit drives checked",
             items_sent, PHASES, chk_drives);
    $display("tb: static and rolling loads, roll ticks, blanking and a long output hold-off");
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: %0d mismatches, %0d drives never seen", chk_fails, chk_pending);
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
